// ----- hdl/jia_pkg.sv -----
package jia_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned CmdWidth  = 4;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_REM  = 4'd4,
    CMD_SHL  = 4'd5,
    CMD_SHR  = 4'd6,
    CMD_USHR = 4'd7,
    CMD_AND  = 4'd8,
    CMD_OR   = 4'd9,
    CMD_XOR  = 4'd10,
    CMD_NEG  = 4'd11
  } cmd_e;

  typedef struct packed {
    logic [CmdWidth-1:0]  cmd;
    logic                 is_long;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
  } op_t;

  // sign-extend the low half
  function automatic logic [DataWidth-1:0] sext32(input logic [DataWidth-1:0] v);
    sext32 = {{(DataWidth/2){v[DataWidth/2-1]}}, v[DataWidth/2-1:0]};
  endfunction

endpackage

// ----- hdl/jia_if.sv -----
interface jia_in_if;
  import jia_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CmdWidth-1:0]  command;
  logic                 is_long;
  logic [DataWidth-1:0] operand_a;
  logic [DataWidth-1:0] operand_b;
  modport source (output valid, command, is_long, operand_a, operand_b, input ready);
  modport sink   (input valid, command, is_long, operand_a, operand_b, output ready);
endinterface

interface jia_out_if;
  import jia_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] result;
  logic                 divide_by_zero;
  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

// ----- hdl/jia_mul.sv -----
// 64x64 low-half multiply from three 32x32 partial products that are registered and then summed
module jia_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [jia_pkg::DataWidth-1:0] a_i,
  input  logic [jia_pkg::DataWidth-1:0] b_i,
  output logic [jia_pkg::DataWidth-1:0] p_o
);
  import jia_pkg::*;
  localparam int unsigned H = DataWidth / 2;

  logic [DataWidth-1:0] ll_q, ll_d;
  logic [H-1:0]         lh_q, lh_d, hl_q, hl_d;

  assign ll_d = {{H{1'b0}}, a_i[H-1:0]} * {{H{1'b0}}, b_i[H-1:0]};
  assign lh_d = a_i[H-1:0] * b_i[DataWidth-1:H];
  assign hl_d = a_i[DataWidth-1:H] * b_i[H-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
    end
  end

  assign p_o = ll_q + {lh_q + hl_q, {H{1'b0}}};
endmodule

// ----- hdl/jia_div_stage.sv -----
// one restoring-division stage handling StepBits quotient bits
module jia_div_stage #(
  parameter int unsigned StepBits = 4
) (
  input  logic [jia_pkg::DataWidth-1:0] rem_i,
  input  logic [jia_pkg::DataWidth-1:0] quo_i,
  input  logic [jia_pkg::DataWidth-1:0] div_i,
  output logic [jia_pkg::DataWidth-1:0] rem_o,
  output logic [jia_pkg::DataWidth-1:0] quo_o
);
  import jia_pkg::*;

  always_comb begin
    logic [DataWidth:0]   r;
    logic [DataWidth-1:0] q;
    logic [DataWidth:0]   t;
    r = {1'b0, rem_i};
    q = quo_i;
    for (int i = 0; i < int'(StepBits); i++) begin
      r = {r[DataWidth-1:0], q[DataWidth-1]};
      q = {q[DataWidth-2:0], 1'b0};
      t = r - {1'b0, div_i};
      if (!t[DataWidth]) begin
        r    = t;
        q[0] = 1'b1;
      end
    end
    rem_o = r[DataWidth-1:0];
    quo_o = q;
  end
endmodule

// ----- hdl/java_integer_alu.sv -----
// Java integer ALU: one int or long bytecode (add, sub, mul, div, rem, shifts, logic, neg)
// per transaction. Fully pipelined: a new transaction is taken every cycle while the output
// is not stalled; the accepting edge loads the operand-prepare stage, which is followed by the
// unsigned divider, 16 stages of 4 quotient bits, then a sign-fix stage and the output
// register. The multiplier uses 32x32 partial products across two stages. A stall on the
// output freezes the whole pipe; ready goes low only when the last stage holds a result
// that is not taken.
module java_integer_alu (
  input logic clk_i,
  input logic rst_ni,
  jia_in_if.sink    in_i,
  jia_out_if.source out_o
);
  import jia_pkg::*;

  localparam int unsigned StepBits  = 4;
  localparam int unsigned DivStages = DataWidth / StepBits;
  localparam int unsigned Depth     = DivStages + 3;

  typedef struct packed {
    logic [CmdWidth-1:0]  cmd;
    logic                 is_long;
    logic                 dz;
    logic                 neg_q;
    logic                 neg_r;
    logic [DataWidth-1:0] fast;
  } meta_t;

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // operand prepare (combinational, registered into stage 0)
  logic [DataWidth-1:0] a, b, ma, mb, fast, diff;
  logic [5:0]           sh;
  always_comb begin
    a  = in_i.is_long ? in_i.operand_a : sext32(in_i.operand_a);
    b  = in_i.is_long ? in_i.operand_b : sext32(in_i.operand_b);
    sh = in_i.is_long ? in_i.operand_b[5:0] : {1'b0, in_i.operand_b[4:0]};
    ma = a[DataWidth-1] ? -a : a;
    mb = b[DataWidth-1] ? -b : b;
    diff = a - b;
    unique case (in_i.command)
      CMD_ADD:  fast = a + b;
      CMD_SUB:  fast = diff;
      CMD_SHL:  fast = a << sh;
      CMD_SHR:  fast = $signed(a) >>> sh;
      CMD_USHR: fast = in_i.is_long ? (a >> sh)
                                    : ({{(DataWidth/2){1'b0}}, a[DataWidth/2-1:0]} >> sh);
      CMD_AND:  fast = a & b;
      CMD_OR:   fast = a | b;
      CMD_XOR:  fast = a ^ b;
      CMD_NEG:  fast = -b;
      default:  fast = '0;
    endcase
  end

  logic                 v_q [Depth];
  meta_t                m_q [DivStages+1];
  logic [DataWidth-1:0] rem_q [DivStages+1];
  logic [DataWidth-1:0] quo_q [DivStages+1];
  logic [DataWidth-1:0] dv_q  [DivStages];
  logic [DataWidth-1:0] rem_w [DivStages];
  logic [DataWidth-1:0] quo_w [DivStages];
  logic [DataWidth-1:0] mul_w;
  logic [DataWidth-1:0] mul_q [DivStages];
  meta_t                m_d;

  always_comb begin
    m_d.cmd     = in_i.command;
    m_d.is_long = in_i.is_long;
    m_d.dz      = (b == '0) && (in_i.command == CMD_DIV || in_i.command == CMD_REM);
    m_d.neg_q   = a[DataWidth-1] ^ b[DataWidth-1];
    m_d.neg_r   = a[DataWidth-1];
    m_d.fast    = fast;
  end

  jia_mul u_mul (.clk_i, .en_i(en), .a_i(a), .b_i(b), .p_o(mul_w));

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    jia_div_stage #(.StepBits(StepBits)) u_stage (
      .rem_i(rem_q[s]), .quo_i(quo_q[s]), .div_i(dv_q[s]),
      .rem_o(rem_w[s]), .quo_o(quo_w[s])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(Depth); i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_i.valid;
      for (int i = 1; i < int'(Depth); i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q[0]   <= m_d;
      rem_q[0] <= '0;
      quo_q[0] <= ma;
      dv_q[0]  <= mb;
      for (int i = 1; i < int'(DivStages) + 1; i++) m_q[i] <= m_q[i-1];
      for (int s = 0; s < int'(DivStages); s++) begin
        rem_q[s+1] <= rem_w[s];
        quo_q[s+1] <= quo_w[s];
      end
      for (int s = 1; s < int'(DivStages); s++) dv_q[s] <= dv_q[s-1];
      // product is ready after stage 0; mul_q[s] travels with stage s+1
      mul_q[0] <= mul_w;
      for (int s = 1; s < int'(DivStages); s++) mul_q[s] <= mul_q[s-1];
    end
  end

  // sign fix and selection, then a staging register and the output register
  logic [DataWidth-1:0] sel, res_d, res_q;
  logic                 dz_q;
  meta_t                mf;
  assign mf = m_q[DivStages];
  always_comb begin
    unique case (mf.cmd)
      CMD_MUL: sel = mul_q[DivStages-1];
      CMD_DIV: sel = mf.neg_q ? -quo_q[DivStages] : quo_q[DivStages];
      CMD_REM: sel = mf.neg_r ? -rem_q[DivStages] : rem_q[DivStages];
      default: sel = mf.fast;
    endcase
    if (mf.dz) sel = '0;
    res_d = mf.is_long ? sel : sext32(sel);
  end

  logic [DataWidth-1:0] st_q;
  logic                 sdz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q  <= res_d;
      sdz_q <= mf.dz;
      res_q <= st_q;
      dz_q  <= sdz_q;
    end
  end

  assign out_o.valid          = v_q[Depth-1];
  assign out_o.result         = res_q;
  assign out_o.divide_by_zero = dz_q;

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.result))
    else $error("stalled result changed");
  // ready only drops while the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input blocked without output stall");
  // divide by zero always yields zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.divide_by_zero |-> out_o.result == '0)
    else $error("nonzero result on divide by zero");
endmodule
